// ===== rtl/core/icr_pkg.sv =====
// icr_pkg: shared types and constants of the in-order completion ring
// no dependencies; imported by every module of the block
package icr_pkg;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned SIZE_W     = IDX_W + 1;

  // configuration port
  localparam int unsigned CAP_W      = 4;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]     CAP_RESET    = 4'd15;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [CAP_W-1:0]     cap_t;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_MARK    = 2'd1,
    OP_POP     = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_EMPTY = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // one operation as held in the input register
  typedef struct packed {
    op_e   opcode;
    idx_t  slot_index;
    code_t completion_code;
  } op_t;

  // one result word
  typedef struct packed {
    status_e status;
    idx_t    granted_slot;
    logic    popped_valid;
    idx_t    popped_slot;
    code_t   popped_code;
    logic    failed;
  } res_t;

endpackage

// ===== rtl/core/in_order_completion_ring_top.sv =====
// in_order_completion_ring_top: reorder ring with in-order retire
// depends on icr_pkg, icr_cfg, icr_ring
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o opcode, slot_index, completion_code
//   out      output     out_valid_o/out_stall_i status, granted_slot, popped_*, failed
//   cfg      apb slave  psel/penable/pready   queue_capacity at byte address 0
//
// one word per cycle sustained while out_stall_i is low; a word is held in the input register,
// is evaluated against the slot flags and pointers, and lands in the result register
// the result register frees up in the same cycle it is taken, so no bubble at full rate
// a stalled output holds its word and backs up into the input register, then in_stall_o
// reset clears flags, pointers and failure latch at once; no clearing pass needed
module in_order_completion_ring_top
  import icr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [3:0]        slot_index_i,
  input  logic [7:0]        completion_code_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [3:0]        granted_slot_o,
  output logic              popped_valid_o,
  output logic [3:0]        popped_slot_o,
  output logic [7:0]        popped_code_o,
  output logic              failed_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // input register stage
  logic s1_valid_q, s1_valid_d;
  op_t  s1_op_q, s1_op_d;
  // result register stage
  logic out_valid_q, out_valid_d;
  res_t out_res_q, out_res_d;

  logic in_take;
  logic out_free;
  logic exec;
  res_t res;
  cap_t cap;

  // the result register can load when empty or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  icr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // state updates only on the cycle the word moves into the result register
  icr_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .op_i   (s1_op_q),
    .cap_i  (cap),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_op_d    = s1_op_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
      s1_op_d    = '{opcode:          op_e'(opcode_i),
                     slot_index:      idx_t'(slot_index_i),
                     completion_code: code_t'(completion_code_i)};
    end else if (exec) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (exec) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    s1_op_q   <= s1_op_d;
    out_res_q <= out_res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign granted_slot_o = 4'(out_res_q.granted_slot);
  assign popped_valid_o = out_res_q.popped_valid;
  assign popped_slot_o  = 4'(out_res_q.popped_slot);
  assign popped_code_o  = 8'(out_res_q.popped_code);
  assign failed_o       = out_res_q.failed;

endmodule

// ===== rtl/core/icr_cfg.sv =====
// icr_cfg: apb register file holding queue_capacity
// depends on icr_pkg
module icr_cfg
  import icr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cap_t              cap_o
);

  cap_t                 cap_q, cap_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_CAPACITY);
  assign pready  = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = (reg_idx == REG_CAPACITY) ? {{(DATA_W - CAP_W){1'b0}}, cap_q} : '0;
  assign cap_o  = cap_q;

endmodule

// ===== rtl/core/icr_ring.sv =====
// icr_ring: slot flags, codes, head/tail pointers and one-op evaluation
// depends on icr_pkg
module icr_ring
  import icr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic exec_i,
  input  op_t  op_i,
  input  cap_t cap_i,
  output res_t res_o
);

  logic [RING_DEPTH-1:0] ready_q, ready_d;
  logic [RING_DEPTH-1:0] occ_q, occ_d;
  code_t                 code_q [RING_DEPTH];
  idx_t                  head_q, head_d;
  idx_t                  tail_q, tail_d;
  logic                  fail_q, fail_d;

  logic  code_we;
  idx_t  code_wa;
  code_t code_wd;

  cap_t  cap_eff;
  size_t cap_plus;
  size_t ring_size;
  idx_t  tail_next;
  idx_t  head_next;
  code_t head_code;

  function automatic idx_t advance(input idx_t idx, input size_t size);
    size_t n;
    n = {1'b0, idx} + size_t'(1);
    return (n >= size) ? '0 : n[IDX_W-1:0];
  endfunction

  // capacity zero behaves as one; ring never exceeds the slot array
  assign cap_eff   = (cap_i == '0) ? cap_t'(1) : cap_i;
  assign cap_plus  = size_t'(cap_eff) + size_t'(1);
  assign ring_size = (cap_plus > size_t'(RING_DEPTH)) ? size_t'(RING_DEPTH) : cap_plus;
  assign tail_next = advance(tail_q, ring_size);
  assign head_next = advance(head_q, ring_size);
  assign head_code = code_q[head_q];

  always_comb begin
    ready_d = ready_q;
    occ_d   = occ_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fail_d  = fail_q;
    code_we = 1'b0;
    code_wa = op_i.slot_index;
    code_wd = op_i.completion_code;
    res_o   = '0;
    res_o.status = ST_OK;
    unique case (op_i.opcode)
      OP_RESERVE: begin
        if (tail_next == head_q) begin
          res_o.status = ST_FULL;
        end else if (ready_q[tail_q] || occ_q[tail_q]) begin
          res_o.status = ST_NOT_EMPTY;
        end else begin
          occ_d[tail_q]      = 1'b1;
          res_o.granted_slot = tail_q;
          tail_d             = tail_next;
        end
      end
      OP_MARK: begin
        if ({1'b0, op_i.slot_index} >= ring_size) begin
          res_o.status = ST_RANGE;
        end else begin
          code_we                  = 1'b1;
          ready_d[op_i.slot_index] = 1'b1;
        end
      end
      OP_POP: begin
        if ((head_q == tail_q) || !ready_q[head_q]) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.popped_valid = 1'b1;
          res_o.popped_slot  = head_q;
          res_o.popped_code  = head_code;
          fail_d             = fail_q | (head_code != '0);
          ready_d[head_q]    = 1'b0;
          occ_d[head_q]      = 1'b0;
          head_d             = head_next;
        end
      end
      OP_NONE: begin
        res_o.status = ST_OK;
      end
      default: begin
        res_o.status = ST_OK;
      end
    endcase
    res_o.failed = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= '0;
      occ_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fail_q  <= 1'b0;
    end else if (exec_i) begin
      ready_q <= ready_d;
      occ_q   <= occ_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fail_q  <= fail_d;
    end
  end

  // a code is only read while its ready bit is set, which a mark always writes
  always_ff @(posedge clk_i) begin
    if (exec_i && code_we) begin
      code_q[code_wa] <= code_wd;
    end
  end

endmodule

// ===== rtl/core/icr_checker.sv =====
// icr_checker: port-level assertions for in_order_completion_ring_top
// depends on icr_pkg; bound to the top level below
module icr_checker
  import icr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [3:0] granted_slot_o,
  input logic       popped_valid_o,
  input logic [7:0] popped_code_o,
  input logic       failed_o
);

  logic seen_fail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fail_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && failed_o) begin
      seen_fail_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(failed_o))
    else $error("stalled result word changed");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_fail_q |-> failed_o)
    else $error("failure flag dropped after being reported");

  a_fail_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && popped_valid_o && (popped_code_o != '0) |-> failed_o)
    else $error("nonzero retire code did not set failure flag");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && popped_valid_o |-> (status_o == ST_OK) && (granted_slot_o == '0))
    else $error("retire reported with bad status or grant");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> !popped_valid_o && (granted_slot_o == '0))
    else $error("error status carried a grant or retire");

endmodule

bind in_order_completion_ring_top icr_checker u_icr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .granted_slot_o (granted_slot_o),
  .popped_valid_o (popped_valid_o),
  .popped_code_o  (popped_code_o),
  .failed_o       (failed_o)
);
